// ----- rtl/core/terrain_quad_hull_offsets_unit_macros.svh -----
// Assertion helpers shared by the terrain quad hull offsets RTL.
// Each check is written against the rising edge of the given clock and is
// switched off while the given active-low reset is asserted.
`ifndef TERRAIN_QUAD_HULL_OFFSETS_UNIT_MACROS_SVH
`define TERRAIN_QUAD_HULL_OFFSETS_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication: whenever pre holds, post must hold too.
`define ASSERT_IMPL(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error("same-cycle check failed");
// Next-cycle implication: whenever pre holds, post must hold in the next cycle.
`define ASSERT_NEXT(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("next-cycle check failed");
`else
`define ASSERT_IMPL(lbl, clk, rstn, pre, post)
`define ASSERT_NEXT(lbl, clk, rstn, pre, post)
`endif

`endif

// ----- rtl/core/tqho_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package tqho_pkg;

    // Opcode carried in the input tuser.
    localparam int OP_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_SAMPLE = 2'd0,
        OP_REPORT = 2'd1,
        OP_CLEAR  = 2'd2
    } op_t;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] REG_CORNER_BL = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CORNER_BR = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CORNER_TL = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_CORNER_TR = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_DIAG      = 3'd4;

    // Positions of the corners in the packed corner arrays.
    localparam int CB_BL = 0;
    localparam int CB_BR = 1;
    localparam int CB_TL = 2;
    localparam int CB_TR = 3;

    // Decoupling queue between front and back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Control part of one queued word.
    typedef struct packed {
        op_t  op;
        logic in_first;
    } tqho_ctl_t;

    // Queue fill status.
    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic              full;
        logic              empty;
    } tqho_qstat_t;

endpackage

`default_nettype wire

// ----- rtl/core/tqho_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tqho_queue #(
    parameter int W = 32
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [W-1:0]          in_data,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [W-1:0]               out_data,
    output tqho_pkg::tqho_qstat_t      stat
);
    import tqho_pkg::*;

    logic [W-1:0]      mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              push, pop;

    assign stat.count = count_reg;
    assign stat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);

    assign in_ready  = !stat.full;
    assign out_valid = !stat.empty;
    assign out_data  = mem_reg[rd_ptr_reg];

    assign push = in_valid && !stat.full;
    assign pop  = out_ready && !stat.empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/tqho_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tqho_front #(
    parameter int HEIGHT_BITS   = 24,
    parameter int POS_FRAC_BITS = 16,
    parameter int IN_DW         = 64
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [IN_DW-1:0]                   s_tdata,
    input  wire logic [tqho_pkg::OP_W-1:0]          s_tuser,
    input  wire logic [3:0][HEIGHT_BITS-1:0]        corners,
    input  wire logic                               sense,
    output logic                                    q_in_valid,
    input  wire logic                               q_in_ready,
    output tqho_pkg::tqho_ctl_t                     q_in_ctl,
    output logic [HEIGHT_BITS-1:0]                  q_in_diff
);
    import tqho_pkg::*;

    localparam int H  = HEIGHT_BITS;
    localparam int P  = POS_FRAC_BITS;
    localparam int PW = H + P + 3;
    localparam int TW = PW - P;
    localparam int DW = H + 5;

    localparam logic [P:0]             POS_ONE  = {1'b1, {P{1'b0}}};
    localparam logic signed [PW-1:0]   HALF_LSB = {{(PW-P){1'b0}}, 1'b1, {(P-1){1'b0}}};
    localparam logic signed [H-1:0]    H_MAX    = {1'b0, {(H-1){1'b1}}};
    localparam logic signed [H-1:0]    H_MIN    = {1'b1, {(H-1){1'b0}}};

    logic en;

    // Stage 1: clamped position, triangle choice, corner deltas and weights.
    logic [P:0]            x_raw, z_raw, x, z, ix, iz;
    logic signed [H-1:0]   sample;
    logic [H-1:0]          base, c1, c2;
    logic [P:0]            w1, w2;
    logic                  first;
    logic                  v1_reg, v1_next;
    tqho_ctl_t             ctl1_reg, ctl1_next;
    logic signed [H-1:0]   base1_reg, base1_next;
    logic signed [H-1:0]   smp1_reg, smp1_next;
    logic signed [H:0]     d1_reg, d1_next, d2_reg, d2_next;
    logic [P:0]            w1_reg, w1_next, w2_reg, w2_next;

    // Stage 2: products and the sample-minus-base term.
    logic                  v2_reg;
    tqho_ctl_t             ctl2_reg;
    logic signed [PW-1:0]  p1_reg, p1_next, p2_reg, p2_next;
    logic signed [H:0]     sb2_reg, sb2_next;

    // Stage 3: rounded interpolation terms.
    logic                  v3_reg;
    tqho_ctl_t             ctl3_reg;
    logic signed [PW-1:0]  r1, r2;
    logic signed [TW-1:0]  t1_reg, t1_next, t2_reg, t2_next;
    logic signed [H:0]     sb3_reg;

    // Stage 4: saturated difference.
    logic                  v4_reg;
    tqho_ctl_t             ctl4_reg;
    logic signed [DW-1:0]  dsum;
    logic [DW-H:0]         dtop;
    logic signed [H-1:0]   diff4_reg, diff4_next;

    // The whole front advances together; it holds only when its last stage
    // has a word the queue cannot take.
    assign en       = !v4_reg || q_in_ready;
    assign s_tready = en;

    always_comb begin
        x_raw  = s_tdata[P:0];
        z_raw  = s_tdata[2*P+1:P+1];
        sample = s_tdata[2*P+H+1:2*P+2];
        x      = (x_raw > POS_ONE) ? POS_ONE : x_raw;
        z      = (z_raw > POS_ONE) ? POS_ONE : z_raw;
        ix     = POS_ONE - x;
        iz     = POS_ONE - z;
        first  = sense ? (ix > z) : (x > z);

        if (sense && first) begin
            base = corners[CB_BL]; c1 = corners[CB_BR]; w1 = x;  c2 = corners[CB_TL]; w2 = z;
        end else if (sense) begin
            base = corners[CB_TR]; c1 = corners[CB_TL]; w1 = ix; c2 = corners[CB_BR]; w2 = iz;
        end else if (first) begin
            base = corners[CB_BR]; c1 = corners[CB_BL]; w1 = ix; c2 = corners[CB_TR]; w2 = z;
        end else begin
            base = corners[CB_TL]; c1 = corners[CB_TR]; w1 = x;  c2 = corners[CB_BL]; w2 = iz;
        end

        v1_next           = s_tvalid && (s_tuser inside {OP_SAMPLE, OP_REPORT, OP_CLEAR});
        ctl1_next.op      = op_t'(s_tuser);
        ctl1_next.in_first = first;
        base1_next        = base;
        smp1_next         = sample;
        d1_next           = {c1[H-1], c1} - {base[H-1], base};
        d2_next           = {c2[H-1], c2} - {base[H-1], base};
        w1_next           = w1;
        w2_next           = w2;
    end

    always_comb begin
        p1_next  = d1_reg * $signed({1'b0, w1_reg});
        p2_next  = d2_reg * $signed({1'b0, w2_reg});
        sb2_next = {smp1_reg[H-1], smp1_reg} - {base1_reg[H-1], base1_reg};
    end

    // Round to nearest, ties toward plus infinity.
    always_comb begin
        r1      = p1_reg + HALF_LSB;
        r2      = p2_reg + HALF_LSB;
        t1_next = r1[PW-1:P];
        t2_next = r2[PW-1:P];
    end

    always_comb begin
        dsum = DW'(sb3_reg) - DW'(t1_reg) - DW'(t2_reg);
        dtop = dsum[DW-1:H-1];
        if ((&dtop) || !(|dtop)) begin
            diff4_next = dsum[H-1:0];
        end else begin
            diff4_next = dsum[DW-1] ? H_MIN : H_MAX;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= v1_next;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ctl1_reg  <= ctl1_next;
            base1_reg <= base1_next;
            smp1_reg  <= smp1_next;
            d1_reg    <= d1_next;
            d2_reg    <= d2_next;
            w1_reg    <= w1_next;
            w2_reg    <= w2_next;
            ctl2_reg  <= ctl1_reg;
            p1_reg    <= p1_next;
            p2_reg    <= p2_next;
            sb2_reg   <= sb2_next;
            ctl3_reg  <= ctl2_reg;
            t1_reg    <= t1_next;
            t2_reg    <= t2_next;
            sb3_reg   <= sb2_reg;
            ctl4_reg  <= ctl3_reg;
            diff4_reg <= diff4_next;
        end
    end

    assign q_in_valid = v4_reg;
    assign q_in_ctl   = ctl4_reg;
    assign q_in_diff  = diff4_reg;

endmodule

`default_nettype wire

// ----- rtl/core/tqho_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tqho_back #(
    parameter int HEIGHT_BITS = 24
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         q_valid,
    input  wire tqho_pkg::tqho_ctl_t          q_ctl,
    input  wire logic [HEIGHT_BITS-1:0]       q_diff,
    output logic                              q_pop,
    input  wire logic [3:0][HEIGHT_BITS-1:0]  corners,
    input  wire logic                         sense,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [8*HEIGHT_BITS-1:0]          m_tdata
);
    import tqho_pkg::*;

    localparam int H = HEIGHT_BITS;
    localparam logic signed [H-1:0] H_MAX = {1'b0, {(H-1){1'b1}}};
    localparam logic signed [H-1:0] H_MIN = {1'b1, {(H-1){1'b0}}};

    logic signed [H-1:0]  lo1_reg, lo1_next, lo2_reg, lo2_next;
    logic signed [H-1:0]  hi1_reg, hi1_next, hi2_reg, hi2_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [8*H-1:0]       m_tdata_reg, m_tdata_next;
    logic signed [H-1:0]  diff, lo, hi;
    logic [3:0][H-1:0]    occ, vis;

    function automatic logic [H-1:0] sat_add(input logic [H-1:0] c, input logic [H-1:0] a);
        logic [H:0] s;
        s = {c[H-1], c} + {a[H-1], a};
        if (s[H] != s[H-1]) begin
            sat_add = s[H] ? H_MIN : H_MAX;
        end else begin
            sat_add = s[H-1:0];
        end
    endfunction

    // a goes to the corner of the first triangle, b to that of the second,
    // c to both corners on the diagonal.
    function automatic logic [3:0][H-1:0] corner_set(input logic sns, input logic [H-1:0] a,
                                                    input logic [H-1:0] b,
                                                    input logic [H-1:0] c);
        logic [3:0][H-1:0] o;
        if (sns) begin
            o[CB_BL] = sat_add(corners[CB_BL], a);
            o[CB_TR] = sat_add(corners[CB_TR], b);
            o[CB_TL] = sat_add(corners[CB_TL], c);
            o[CB_BR] = sat_add(corners[CB_BR], c);
        end else begin
            o[CB_BR] = sat_add(corners[CB_BR], a);
            o[CB_TL] = sat_add(corners[CB_TL], b);
            o[CB_TR] = sat_add(corners[CB_TR], c);
            o[CB_BL] = sat_add(corners[CB_BL], c);
        end
        corner_set = o;
    endfunction

    // Samples and clears never wait; a report waits for the output register.
    assign q_pop = q_valid && ((q_ctl.op != OP_REPORT) || !m_tvalid_reg || m_tready);
    assign diff  = q_diff;

    always_comb begin
        lo  = (lo1_reg < lo2_reg) ? lo1_reg : lo2_reg;
        hi  = (hi1_reg > hi2_reg) ? hi1_reg : hi2_reg;
        occ = corner_set(sense, lo1_reg, lo2_reg, lo);
        vis = corner_set(sense, hi1_reg, hi2_reg, hi);
    end

    always_comb begin
        lo1_next      = lo1_reg;
        lo2_next      = lo2_reg;
        hi1_next      = hi1_reg;
        hi2_next      = hi2_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        if (q_pop) begin
            case (q_ctl.op)
                OP_SAMPLE: begin
                    if (q_ctl.in_first) begin
                        if (diff > hi1_reg) hi1_next = diff;
                        if (diff < lo1_reg) lo1_next = diff;
                    end else begin
                        if (diff > hi2_reg) hi2_next = diff;
                        if (diff < lo2_reg) lo2_next = diff;
                    end
                end
                OP_REPORT: begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {vis, occ};
                end
                OP_CLEAR: begin
                    lo1_next = '0;
                    lo2_next = '0;
                    hi1_next = '0;
                    hi2_next = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lo1_reg      <= '0;
            lo2_reg      <= '0;
            hi1_reg      <= '0;
            hi2_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            lo1_reg      <= lo1_next;
            lo2_reg      <= lo2_next;
            hi1_reg      <= hi1_next;
            hi2_reg      <= hi2_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

// ----- rtl/core/terrain_quad_hull_offsets_unit.sv -----
// Channel   Dir  Handshake           Payload
// s_        in   s_tvalid/s_tready   tuser: opcode; tdata: pos_x, pos_z, sample_height
// m_        out  m_tvalid/m_tready   tdata: occ corners BL,BR,TL,TR then vis corners
// cfg_      in   cfg_we              cfg_addr selects the register, cfg_wdata holds it
//
// One input word is taken every clock cycle while the front is not held; words pass
// the four-stage front (select, multiply, round, saturate) on their way to the queue.
// A report word passes the front stages, the queue and the output register before it reaches m_tdata.
// Reset is synchronous on aresetn low and needs no clearing pass.
// s_tready drops only while the four-word queue is full and the front's
// last stage holds a word; the back stalls only on a report while a result waits and m_tready is low.
`timescale 1ns / 1ps
`default_nettype none
`include "terrain_quad_hull_offsets_unit_macros.svh"

module terrain_quad_hull_offsets_unit #(
    parameter int HEIGHT_BITS   = 24,
    parameter int POS_FRAC_BITS = 16
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    // Input words.
    input  wire logic                                   s_tvalid,
    output logic                                        s_tready,
    // Bits from the lowest up: pos_x, pos_z, sample_height, zero padding.
    input  wire logic [((2*(POS_FRAC_BITS+1)+HEIGHT_BITS+7)/8)*8-1:0] s_tdata,
    // Bits from the lowest up: opcode.
    input  wire logic [tqho_pkg::OP_W-1:0]              s_tuser,
    // Result words.
    output logic                                        m_tvalid,
    input  wire logic                                   m_tready,
    // Bits from the lowest up: occ_bottom_left, occ_bottom_right, occ_top_left,
    // occ_top_right, vis_bottom_left, vis_bottom_right, vis_top_left, vis_top_right.
    output logic [8*HEIGHT_BITS-1:0]                    m_tdata,
    // Configuration writes.
    input  wire logic                                   cfg_we,
    input  wire logic [tqho_pkg::CFG_INDEX_W-1:0]       cfg_addr,
    input  wire logic [HEIGHT_BITS-1:0]                 cfg_wdata
);
    import tqho_pkg::*;

    localparam int H     = HEIGHT_BITS;
    localparam int IN_DW = ((2*(POS_FRAC_BITS+1)+HEIGHT_BITS+7)/8)*8;
    localparam int QW    = $bits(tqho_ctl_t) + HEIGHT_BITS;

    // Quad configuration. The user must write these only while the block is idle;
    // the block does not enforce this, and both halves read these registers directly.
    logic [3:0][H-1:0] corners_reg, corners_next;
    logic              sense_reg, sense_next;

    logic              q_in_valid, q_in_ready;
    tqho_ctl_t         q_in_ctl;
    logic [H-1:0]      q_in_diff;
    logic              q_out_valid, q_pop;
    logic [QW-1:0]     q_out_data;
    tqho_ctl_t         q_out_ctl;
    logic [H-1:0]      q_out_diff;
    tqho_qstat_t       q_stat;

    always_comb begin
        corners_next = corners_reg;
        sense_next   = sense_reg;
        if (cfg_we) begin
            case (cfg_addr)
                REG_CORNER_BL: corners_next[CB_BL] = cfg_wdata;
                REG_CORNER_BR: corners_next[CB_BR] = cfg_wdata;
                REG_CORNER_TL: corners_next[CB_TL] = cfg_wdata;
                REG_CORNER_TR: corners_next[CB_TR] = cfg_wdata;
                REG_DIAG:      sense_next          = cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            corners_reg <= '0;
            sense_reg   <= 1'b0;
        end else begin
            corners_reg <= corners_next;
            sense_reg   <= sense_next;
        end
    end

    // The front classifies each word, picks its triangle and computes the
    // saturated height difference; words with no meaning are dropped there.
    tqho_front #(
        .HEIGHT_BITS   (HEIGHT_BITS),
        .POS_FRAC_BITS (POS_FRAC_BITS),
        .IN_DW         (IN_DW)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .corners    (corners_reg),
        .sense      (sense_reg),
        .q_in_valid (q_in_valid),
        .q_in_ready (q_in_ready),
        .q_in_ctl   (q_in_ctl),
        .q_in_diff  (q_in_diff)
    );

    // The queue keeps sample, clear and report words in order so that the
    // front keeps streaming while a report waits on the output.
    tqho_queue #(
        .W (QW)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (q_in_valid),
        .in_ready  (q_in_ready),
        .in_data   ({q_in_ctl, q_in_diff}),
        .out_valid (q_out_valid),
        .out_ready (q_pop),
        .out_data  (q_out_data),
        .stat      (q_stat)
    );

    assign q_out_ctl  = tqho_ctl_t'(q_out_data[QW-1:H]);
    assign q_out_diff = q_out_data[H-1:0];

    // The back owns the four running extremes and the output register.
    tqho_back #(
        .HEIGHT_BITS (HEIGHT_BITS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_out_valid),
        .q_ctl    (q_out_ctl),
        .q_diff   (q_out_diff),
        .q_pop    (q_pop),
        .corners  (corners_reg),
        .sense    (sense_reg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // The queue never holds more words than it has room for.
    `ASSERT_IMPL(a_queue_bound, aclk, aresetn, 1'b1, q_stat.count <= QCNT_W'(QUEUE_DEPTH))
    // The input side stalls only because the queue is full.
    `ASSERT_IMPL(a_stall_cause, aclk, aresetn, !s_tready, q_stat.full)
    // A report taken from the queue shows up on the output in the next cycle.
    `ASSERT_NEXT(a_report_out, aclk, aresetn, q_pop && (q_out_ctl.op == OP_REPORT), m_tvalid)
    // A waiting result is never overwritten by the next report.
    `ASSERT_IMPL(a_no_overwrite, aclk, aresetn, m_tvalid && !m_tready,
                 !(q_pop && (q_out_ctl.op == OP_REPORT)))

endmodule

`default_nettype wire
